@@ hw/rtl/itt_pkg.sv @@
package itt_pkg;

   localparam int MAX_WORKERS_DEFAULT = 16;

   localparam int DIVIDEND_W = 63;
   localparam int DIVISOR_W  = 32;
   localparam int QUOT_W     = 32;

   localparam logic [31:0] NOT_IDLE = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_ACTIVE  = 2'd0,
      MODE_PENDING = 2'd1,
      MODE_DONE    = 2'd2
   } mode_type;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_ACTIVE = 3'd1;
   localparam logic [2:0] KIND_IDLE   = 3'd2;
   localparam logic [2:0] KIND_DONE   = 3'd3;

   localparam logic [2:0] CSR_COLLECT_ENABLED    = 3'd0;
   localparam logic [2:0] CSR_IDLE_DELAY_TICKS   = 3'd1;
   localparam logic [2:0] CSR_MIN_SPACING_TICKS  = 3'd2;
   localparam logic [2:0] CSR_TICK_PERIOD        = 3'd3;
   localparam logic [2:0] CSR_KEEP_TIMER_RUNNING = 3'd4;
   localparam logic [2:0] CSR_WORKERS_IN_USE     = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_TRIG,
      ST_DIV,
      ST_RESULT
   } state_type;

   // Signed less-than on two raw 32-bit patterns.
   function automatic logic slt32(input logic [31:0] a, input logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

@@ hw/rtl/itt_div.sv @@
module itt_div import itt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [QUOT_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [QUOT_W-1:0]     quo_ff;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [DIVISOR_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dsr_ff <= divisor;
         dvd_ff <= dividend;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUOT_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/idle_trigger_tracker.sv @@
// One beat in gives one beat out. A status query, a collection-done beat, a worker-idle
// beat and a worker-active beat that does not resume the timer pass from accept through
// the execute state to the result state. A tick that is allowed to trigger reads the idle
// stamps of the workers in use from the stamp memory one at a time, with a read state and
// a check state for each, stopping at the first worker that is not idle long enough. A
// worker-active beat that resumes the timer runs the missed-tick division one quotient bit
// per cycle. The input is taken again as soon as the result is placed in the output
// register, so a waiting result does not hold up taking the next beat.
module idle_trigger_tracker import itt_pkg::*; #(
   parameter int MAX_WORKERS = MAX_WORKERS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic [3:0]         req_worker_index,
   input  logic               req_just_awoke,
   input  logic [62:0]        req_elapsed_time,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_mode,
   output logic               rsp_collect_pending,
   output logic               rsp_wake_request,
   output logic               rsp_timer_pause,
   output logic               rsp_timer_resume,
   output logic signed [31:0] rsp_tick_now,

   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int WCNT = $clog2(MAX_WORKERS + 1);

   // Configuration registers.
   logic        collect_enabled_ff;
   logic [30:0] idle_delay_ff;
   logic [30:0] min_spacing_ff;
   logic [31:0] tick_period_ff;
   logic        keep_timer_ff;
   logic [4:0]  workers_in_use_ff;

   // Control state.
   state_type   state_ff, state_in;
   mode_type    mode_ff;
   logic [31:0] tick_count_ff;
   logic [31:0] last_collect_ff;
   logic [62:0] pause_stamp_ff;
   logic [MAX_WORKERS-1:0] stamp_valid_ff;
   logic        wake_ff, pause_ff, resume_ff;
   logic [WCNT-1:0] scan_cnt_ff;

   // Item and working registers.
   logic [2:0]  item_kind_ff;
   logic [3:0]  item_idx_ff;
   logic        item_awoke_ff;
   logic [62:0] item_now_ff;
   logic [31:0] tick_ref_ff;
   logic        neg_ff;

   // Stamp memory.
   logic [31:0] stamp_mem [MAX_WORKERS];
   logic [31:0] rd_data_ff;
   logic        rd_valid_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [1:0]  rsp_mode_ff;
   logic        rsp_pending_ff, rsp_wake_ff, rsp_pause_ff, rsp_resume_ff;
   logic [31:0] rsp_tick_ff;

   logic            accept;
   logic            idx_in_range;
   logic [WIDX-1:0] wr_addr;
   logic [WIDX-1:0] rd_addr;
   logic [WCNT-1:0] scan_limit;
   logic            spacing_block;
   logic            scan_done;
   logic [31:0]     stamp;
   logic            scan_fail;
   logic            will_resume;
   logic            out_free;
   logic [31:0]     divisor;
   logic [62:0]     dividend;
   logic            now_below;
   logic            div_start;
   logic            div_done;
   logic [31:0]     div_quot;
   logic [31:0]     missed;

   // Control outputs of the sequencer.
   logic mem_write, valid_clear, mem_read, trig_apply, add_missed, load_rsp;

   assign accept       = req_valid && !req_stall;
   assign idx_in_range = 32'(item_idx_ff) < MAX_WORKERS;
   assign wr_addr      = WIDX'(item_idx_ff);
   assign rd_addr      = scan_cnt_ff[WIDX-1:0];
   assign scan_limit   = (32'(workers_in_use_ff) > MAX_WORKERS) ? WCNT'(MAX_WORKERS)
                                                                 : WCNT'(workers_in_use_ff);
   assign spacing_block = (min_spacing_ff != '0)
                       && slt32(tick_count_ff - last_collect_ff, {1'b0, min_spacing_ff});
   assign scan_done   = scan_cnt_ff == scan_limit;
   assign stamp       = rd_valid_ff ? rd_data_ff : NOT_IDLE;
   assign scan_fail   = (stamp == NOT_IDLE) || slt32(tick_ref_ff - stamp, {1'b0, idle_delay_ff});
   assign will_resume = item_awoke_ff && (mode_ff != MODE_ACTIVE) && !keep_timer_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign divisor   = (tick_period_ff == '0) ? 32'd1 : tick_period_ff;
   assign now_below = item_now_ff < pause_stamp_ff;
   assign dividend  = now_below ? pause_stamp_ff - item_now_ff : item_now_ff - pause_stamp_ff;
   assign missed    = neg_ff ? 32'd0 - div_quot : div_quot;

   itt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (item_kind_ff)
               KIND_TICK: begin
                  if (mode_ff != MODE_ACTIVE || spacing_block) state_in = ST_RESULT;
                  else state_in = ST_SCAN_RD;
               end
               KIND_ACTIVE: begin
                  state_in = will_resume ? ST_DIV : ST_RESULT;
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_SCAN_RD: begin
            state_in = scan_done ? ST_TRIG : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = scan_fail ? ST_RESULT : ST_SCAN_RD;
         end
         ST_TRIG: state_in = ST_RESULT;
         ST_DIV: begin
            if (div_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = state_ff != ST_IDLE;
      mem_write   = 1'b0;
      valid_clear = 1'b0;
      mem_read    = 1'b0;
      div_start   = 1'b0;
      trig_apply  = 1'b0;
      add_missed  = 1'b0;
      load_rsp    = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            mem_write   = (item_kind_ff == KIND_IDLE) && idx_in_range;
            valid_clear = (item_kind_ff == KIND_ACTIVE) && idx_in_range;
            div_start   = (item_kind_ff == KIND_ACTIVE) && will_resume;
         end
         ST_SCAN_RD:  mem_read   = !scan_done;
         ST_TRIG:     trig_apply = 1'b1;
         ST_DIV:      add_missed = div_done;
         ST_RESULT:   load_rsp   = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_write) stamp_mem[wr_addr] <= tick_count_ff;
      if (mem_read) begin
         rd_data_ff  <= stamp_mem[rd_addr];
         rd_valid_ff <= stamp_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_kind_ff  <= req_kind;
         item_idx_ff   <= req_worker_index;
         item_awoke_ff <= req_just_awoke;
         item_now_ff   <= req_elapsed_time;
      end
      if (state_ff == ST_EXEC) begin
         tick_ref_ff <= tick_count_ff;
         neg_ff      <= now_below;
      end
      if (load_rsp) begin
         rsp_mode_ff    <= mode_ff;
         rsp_pending_ff <= mode_ff == MODE_PENDING;
         rsp_wake_ff    <= wake_ff;
         rsp_pause_ff   <= pause_ff;
         rsp_resume_ff  <= resume_ff;
         rsp_tick_ff    <= tick_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collect_enabled_ff <= 1'b0;
         idle_delay_ff      <= 31'd1;
         min_spacing_ff     <= '0;
         tick_period_ff     <= 32'd10_000_000;
         keep_timer_ff      <= 1'b0;
         workers_in_use_ff  <= 5'd1;
         state_ff           <= ST_IDLE;
         mode_ff            <= MODE_ACTIVE;
         tick_count_ff      <= '0;
         last_collect_ff    <= '0;
         pause_stamp_ff     <= '0;
         stamp_valid_ff     <= '0;
         wake_ff            <= 1'b0;
         pause_ff           <= 1'b0;
         resume_ff          <= 1'b0;
         scan_cnt_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            case (csr_index)
               CSR_COLLECT_ENABLED:    collect_enabled_ff <= csr_wdata[0];
               CSR_IDLE_DELAY_TICKS:   idle_delay_ff      <= csr_wdata[30:0];
               CSR_MIN_SPACING_TICKS: begin
                  min_spacing_ff  <= csr_wdata[30:0];
                  last_collect_ff <= 32'd0 - {1'b0, csr_wdata[30:0]};
               end
               CSR_TICK_PERIOD:        tick_period_ff     <= csr_wdata;
               CSR_KEEP_TIMER_RUNNING: keep_timer_ff      <= csr_wdata[0];
               CSR_WORKERS_IN_USE:     workers_in_use_ff  <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end

         if (accept) begin
            wake_ff   <= 1'b0;
            pause_ff  <= 1'b0;
            resume_ff <= 1'b0;
         end

         if (mem_write) stamp_valid_ff[wr_addr] <= 1'b1;
         if (valid_clear) stamp_valid_ff[wr_addr] <= 1'b0;

         if (state_ff == ST_EXEC) begin
            scan_cnt_ff <= '0;
            case (item_kind_ff)
               KIND_TICK: tick_count_ff <= tick_count_ff + 32'd1;
               KIND_ACTIVE: begin
                  if (item_awoke_ff && mode_ff != MODE_ACTIVE) begin
                     mode_ff   <= MODE_ACTIVE;
                     resume_ff <= !keep_timer_ff;
                  end
               end
               KIND_DONE: begin
                  last_collect_ff <= tick_count_ff;
                  mode_ff         <= MODE_DONE;
               end
               default: begin
               end
            endcase
         end

         if (state_ff == ST_SCAN_CHK && !scan_fail) scan_cnt_ff <= scan_cnt_ff + 1'b1;

         if (trig_apply) begin
            mode_ff <= collect_enabled_ff ? MODE_PENDING : MODE_DONE;
            wake_ff <= collect_enabled_ff;
            if (!keep_timer_ff) begin
               pause_ff       <= 1'b1;
               pause_stamp_ff <= item_now_ff;
            end
         end

         if (add_missed) tick_count_ff <= tick_count_ff + missed;

         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode            = rsp_mode_ff;
   assign rsp_collect_pending = rsp_pending_ff;
   assign rsp_wake_request    = rsp_wake_ff;
   assign rsp_timer_pause     = rsp_pause_ff;
   assign rsp_timer_resume    = rsp_resume_ff;
   assign rsp_tick_now        = $signed(rsp_tick_ff);

endmodule
